[rtl/cosine_top_k_search_assert.svh]
// Assertion macros for the cosine top-k search RTL.
`ifndef COSINE_TOP_K_SEARCH_ASSERT_SVH
`define COSINE_TOP_K_SEARCH_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define CTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cts_pkg.sv]
// Types and constants for the cosine top-k search block.
package cts_pkg;

  localparam int ScoreW = 16;
  localparam int QBits  = 15;

  localparam logic signed [ScoreW-1:0] ScoreMax = 16'sh7fff;
  localparam logic signed [ScoreW-1:0] ScoreMin = 16'sh8000;

  localparam logic [1:0] StMatch  = 2'd0;
  localparam logic [1:0] StStored = 2'd1;
  localparam logic [1:0] StFull   = 2'd2;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] value;
    logic               last;
    logic [6:0]         top_k;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         entry_index;
    logic signed [15:0] score;
    logic [1:0]         status;
    logic               last_res;
  } out_item_t;

endpackage

[rtl/cosine_top_k_search.sv]
// Cosine top-k search: vector store, scoring sequencer and top-k selection.
//
// Input channel (in_valid_i/in_ready_o/in_item_i): one vector element per item.
// kind 0 elements fill the next free slot, kind 1 elements fill the query.
// last closes a vector; missing trailing elements are zero-padded, one per
// cycle, before the block takes another item. Extra elements are dropped.
// A store vector gives one item (status stored or full) when its last element
// is accepted. A query starts the search: the query norm is one square root,
// then every stored slot is streamed through a multiply-accumulate pipe,
// its norm taken by the shared square root unit and its score by the
// shared divider. Selection then walks the score memory once per result,
// best first, ties to the lower slot. Loading streams at one element per
// cycle; input is stalled during padding, the closing step and search. The
// output register holds an item while the receiver stalls; the sequencer
// waits on it and the input waits if a result is pending.
// Reset empties the store and element counter; no clearing pass is needed.
module cosine_top_k_search import cts_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int DIM     = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  `include "cosine_top_k_search_assert.svh"

  localparam int SlotW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CntW  = $clog2(ENTRIES + 1);
  localparam int IdxW  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int PosW  = $clog2(DIM + 1);
  localparam int MemD  = ENTRIES * DIM;
  localparam int AddrW = (MemD > 1) ? $clog2(MemD) : 1;
  localparam int BaseW = AddrW + 1;
  localparam int AccW  = 32 + $clog2(DIM);
  localparam int NormW = (AccW + 1) / 2;
  localparam int DenW  = 2 * NormW;

  typedef enum logic [3:0] {
    S_IDLE, S_PAD, S_FIN, S_QGO, S_QWAIT, S_SLOT, S_DOT, S_SGO, S_SWAIT,
    S_DEN, S_DGO, S_DWAIT, S_SELINIT, S_SCAN, S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic [PosW-1:0]  pos_q, pos_d, rd_i_q, rd_i_d;
  logic [CntW-1:0]  entry_count_q, entry_count_d, sel_j_q, sel_j_d;
  logic [BaseW-1:0] wr_base_q, wr_base_d, rd_base_q, rd_base_d;
  logic             lkind_q, lkind_d, search_q, search_d;
  logic [6:0]       top_n_q, top_n_d, emit_cnt_q, emit_cnt_d;
  logic [SlotW-1:0] slot_q, slot_d, sc_j_q, best_idx_q, best_idx_d;
  logic             rd_v_q, rd_v_d, p_v_q, sc_v_q, sc_v_d, found_q, found_d;
  logic [ENTRIES-1:0] used_q, used_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic [AccW-1:0]        qq_q, qq_d, ss_q;
  logic signed [AccW-1:0] dot_q;
  logic [NormW-1:0]       nq_q, nq_d, ns_q, ns_d;
  logic [DenW-1:0]        den_q;
  logic signed [31:0]     p_dot_q, p_ss_q, vsq;
  logic signed [ScoreW-1:0] best_sc_q, best_sc_d;

  logic signed [15:0] store_mem [MemD];
  logic signed [15:0] query_mem [DIM];
  logic signed [ScoreW-1:0] score_mem [ENTRIES];
  logic signed [15:0] store_rd_q, query_rd_q;
  logic signed [ScoreW-1:0] score_rd_q;

  logic in_acc, out_free, slot_free, pos_ok, wr_act, pad, issue, sc_issue;
  logic sq_start, sq_done, div_start, div_done;
  logic [AccW-1:0] sq_x;
  logic [NormW-1:0] sq_res;
  logic signed [ScoreW-1:0] div_score;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [6:0] ec7;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = entry_count_q < CntW'(ENTRIES);
  assign pos_ok     = pos_q < PosW'(DIM);
  assign pad        = state_q == S_PAD;
  assign wr_act     = (in_acc && pos_ok) || pad;
  assign wr_addr    = AddrW'(wr_base_q + BaseW'(pos_q));
  assign rd_addr    = AddrW'(rd_base_q + BaseW'(rd_i_q));
  assign issue      = (state_q == S_DOT) && (rd_i_q < PosW'(DIM));
  assign sc_issue   = (state_q == S_SCAN) && (sel_j_q < entry_count_q);
  assign vsq        = in_item_i.value * in_item_i.value;
  assign ec7        = 7'(entry_count_q);
  assign sq_start   = (state_q == S_QGO) || (state_q == S_SGO);
  assign sq_x       = (state_q == S_QGO) ? qq_q : ss_q;
  assign div_start  = state_q == S_DGO;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  cts_isqrt #(.InW(AccW)) u_isqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .x_i(sq_x), .done_o(sq_done), .res_o(sq_res)
  );

  cts_div #(.AccW(AccW), .DenW(DenW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dot_i(dot_q), .den_i(den_q),
    .done_o(div_done), .score_o(div_score)
  );

  // Memories: each element goes to both buffers (the store only while a slot is free), zero to the other kind.
  always_ff @(posedge clk_i) begin
    if (wr_act && slot_free) begin
      store_mem[wr_addr] <= (pad || in_item_i.kind) ? 16'sd0 : in_item_i.value;
    end
    if (wr_act) begin
      query_mem[pos_q[IdxW-1:0]] <= (pad || !in_item_i.kind) ? 16'sd0 : in_item_i.value;
    end
    if (issue) begin
      store_rd_q <= store_mem[rd_addr];
      query_rd_q <= query_mem[rd_i_q[IdxW-1:0]];
    end
    if (state_q == S_DWAIT && div_done) begin
      score_mem[slot_q] <= div_score;
    end
    if (sc_issue) begin
      score_rd_q <= score_mem[sel_j_q[SlotW-1:0]];
    end
  end

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    rd_i_d        = rd_i_q;
    entry_count_d = entry_count_q;
    sel_j_d       = sel_j_q;
    wr_base_d     = wr_base_q;
    rd_base_d     = rd_base_q;
    lkind_d       = lkind_q;
    search_d      = search_q;
    top_n_d       = top_n_q;
    emit_cnt_d    = emit_cnt_q;
    slot_d        = slot_q;
    best_idx_d    = best_idx_q;
    best_sc_d     = best_sc_q;
    found_d       = found_q;
    used_d        = used_q;
    rd_v_d        = issue;
    sc_v_d        = sc_issue;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_d         = out_q;
    qq_d          = qq_q;
    nq_d          = nq_q;
    ns_d          = ns_q;

    if (in_acc) begin
      qq_d = ((pos_q == '0) ? '0 : qq_q) +
             ((pos_ok && in_item_i.kind) ? AccW'(unsigned'(vsq)) : '0);
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (pos_ok) pos_d = pos_q + 1'b1;
          if (in_item_i.last) begin
            lkind_d  = in_item_i.kind;
            top_n_d  = (in_item_i.top_k < ec7) ? in_item_i.top_k : ec7;
            search_d = in_item_i.kind && (in_item_i.top_k != '0) && (ec7 != '0);
            if (!in_item_i.kind) begin
              out_valid_d       = 1'b1;
              out_d.entry_index = slot_free ? 6'(entry_count_q) : 6'd0;
              out_d.score       = '0;
              out_d.status      = slot_free ? StStored : StFull;
              out_d.last_res    = 1'b1;
            end
            state_d = (pos_q < PosW'(DIM - 1)) ? S_PAD : S_FIN;
          end
        end
      end
      S_PAD: begin
        pos_d = pos_q + 1'b1;
        if (pos_q == PosW'(DIM - 1)) state_d = S_FIN;
      end
      S_FIN: begin
        pos_d = '0;
        if (!lkind_q && slot_free) begin
          entry_count_d = entry_count_q + 1'b1;
          wr_base_d     = wr_base_q + BaseW'(DIM);
        end
        state_d = search_q ? S_QGO : S_IDLE;
      end
      S_QGO: state_d = S_QWAIT;
      S_QWAIT: begin
        if (sq_done) begin
          nq_d      = sq_res;
          slot_d    = '0;
          rd_base_d = '0;
          used_d    = '0;
          emit_cnt_d = '0;
          state_d   = S_SLOT;
        end
      end
      S_SLOT: begin
        rd_i_d  = '0;
        state_d = S_DOT;
      end
      S_DOT: begin
        if (issue) rd_i_d = rd_i_q + 1'b1;
        else if (!rd_v_q && !p_v_q) state_d = S_SGO;
      end
      S_SGO: state_d = S_SWAIT;
      S_SWAIT: begin
        if (sq_done) begin
          ns_d    = sq_res;
          state_d = S_DEN;
        end
      end
      S_DEN: state_d = S_DGO;
      S_DGO: state_d = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          if (CntW'(slot_q) + 1'b1 == entry_count_q) begin
            state_d = S_SELINIT;
          end else begin
            slot_d    = slot_q + 1'b1;
            rd_base_d = rd_base_q + BaseW'(DIM);
            state_d   = S_SLOT;
          end
        end
      end
      S_SELINIT: begin
        sel_j_d = '0;
        found_d = 1'b0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sc_issue) sel_j_d = sel_j_q + 1'b1;
        if (sc_v_q && !used_q[sc_j_q] && (!found_q || score_rd_q > best_sc_q)) begin
          found_d    = 1'b1;
          best_idx_d = sc_j_q;
          best_sc_d  = score_rd_q;
        end
        if (!sc_issue && !sc_v_q) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.entry_index   = 6'(best_idx_q);
          out_d.score         = best_sc_q;
          out_d.status        = StMatch;
          out_d.last_res      = (emit_cnt_q + 7'd1 == top_n_q);
          used_d[best_idx_q]  = 1'b1;
          emit_cnt_d          = emit_cnt_q + 7'd1;
          state_d = (emit_cnt_q + 7'd1 == top_n_q) ? S_IDLE : S_SELINIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      pos_q         <= '0;
      rd_i_q        <= '0;
      entry_count_q <= '0;
      sel_j_q       <= '0;
      wr_base_q     <= '0;
      rd_base_q     <= '0;
      lkind_q       <= 1'b0;
      search_q      <= 1'b0;
      top_n_q       <= '0;
      emit_cnt_q    <= '0;
      slot_q        <= '0;
      rd_v_q        <= 1'b0;
      p_v_q         <= 1'b0;
      sc_v_q        <= 1'b0;
      found_q       <= 1'b0;
      used_q        <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      state_q       <= state_d;
      pos_q         <= pos_d;
      rd_i_q        <= rd_i_d;
      entry_count_q <= entry_count_d;
      sel_j_q       <= sel_j_d;
      wr_base_q     <= wr_base_d;
      rd_base_q     <= rd_base_d;
      lkind_q       <= lkind_d;
      search_q      <= search_d;
      top_n_q       <= top_n_d;
      emit_cnt_q    <= emit_cnt_d;
      slot_q        <= slot_d;
      rd_v_q        <= rd_v_d;
      p_v_q         <= rd_v_q;
      sc_v_q        <= sc_v_d;
      found_q       <= found_d;
      used_q        <= used_d;
      out_valid_q   <= out_valid_d;
      out_q         <= out_d;
    end
  end

  // Datapath: products registered, then accumulated.
  always_ff @(posedge clk_i) begin
    qq_q       <= qq_d;
    nq_q       <= nq_d;
    ns_q       <= ns_d;
    best_idx_q <= best_idx_d;
    best_sc_q  <= best_sc_d;
    sc_j_q     <= sel_j_q[SlotW-1:0];
    p_dot_q    <= query_rd_q * store_rd_q;
    p_ss_q     <= store_rd_q * store_rd_q;
    den_q      <= DenW'(nq_q) * DenW'(ns_q);
    if (state_q == S_SLOT) begin
      dot_q <= '0;
      ss_q  <= '0;
    end else if (p_v_q) begin
      dot_q <= dot_q + AccW'(p_dot_q);
      ss_q  <= ss_q + AccW'(unsigned'(p_ss_q));
    end
  end

  `CTS_ASSERT_IMPL(a_ready_idle, in_ready_o, state_q == S_IDLE, "ready outside idle")
  `CTS_ASSERT_IMPL(a_cnt_max, 1'b1, entry_count_q <= CntW'(ENTRIES), "entry count overflow")
  `CTS_ASSERT_IMPL(a_emit_n, state_q == S_EMIT, emit_cnt_q < top_n_q, "too many results")
  `CTS_ASSERT_IMPL(a_used, state_q == S_SCAN, $countones(used_q) == emit_cnt_q,
                   "used marks out of step")
  `CTS_ASSERT_NEXT(a_fin_pos, state_q == S_FIN, pos_q == '0, "position not cleared")

endmodule

[rtl/cts_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
module cts_isqrt import cts_pkg::*; #(
  parameter int InW = 38
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [InW-1:0]            x_i,
  output logic                      done_o,
  output logic [(InW+InW%2)/2-1:0]  res_o
);

  localparam int EvW  = InW + InW % 2;
  localparam int OutW = EvW / 2;
  localparam int CntW = $clog2(OutW + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [EvW-1:0]  x_q, res_q, bit_q;
  logic [EvW-1:0]  trial;

  assign trial  = res_q + bit_q;
  assign done_o = done_q;
  assign res_o  = res_q[OutW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(OutW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= EvW'(x_i);
      res_q <= '0;
      bit_q <= EvW'(1) << (EvW - 2);
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

[rtl/cts_div.sv]
// Iterative restoring divider producing a saturated Q1.15 cosine score.
module cts_div import cts_pkg::*; #(
  parameter int AccW = 38,
  parameter int DenW = 38
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [AccW-1:0]   dot_i,
  input  logic [DenW-1:0]          den_i,
  output logic                     done_o,
  output logic signed [ScoreW-1:0] score_o
);

  localparam int RW = ((AccW > DenW) ? AccW : DenW) + 1;

  logic                     busy_q, done_q, neg_q;
  logic [3:0]               cnt_q;
  logic [RW-1:0]            rem_q, den_q, r2;
  logic [QBits-1:0]         quo_q, quo_n;
  logic signed [ScoreW-1:0] score_q;
  logic [AccW-1:0]          mag;

  assign mag     = dot_i[AccW-1] ? AccW'(-dot_i) : AccW'(dot_i);
  assign r2      = rem_q << 1;
  assign quo_n   = {quo_q[QBits-2:0], (r2 >= den_q)};
  assign done_o  = done_q;
  assign score_o = score_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        // zero norm or |q| >= 1.0 finish at once
        if (den_i == '0 || RW'(mag) >= RW'(den_i)) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'(QBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dot_i[AccW-1];
      rem_q <= RW'(mag);
      den_q <= RW'(den_i);
      quo_q <= '0;
      if (den_i == '0) begin
        score_q <= '0;
      end else if (RW'(mag) >= RW'(den_i)) begin
        score_q <= dot_i[AccW-1] ? ScoreMin : ScoreMax;
      end
    end else if (busy_q) begin
      rem_q <= (r2 >= den_q) ? r2 - den_q : r2;
      quo_q <= quo_n;
      if (cnt_q == 4'(QBits - 1)) begin
        score_q <= neg_q ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});
      end
    end
  end

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the cosine top-k search block.
module tb;
  import cts_pkg::*;

  localparam int Slots  = 64;
  localparam int Dim    = 64;
  localparam int NItems = 460;
  localparam int Limit  = 40_000_000;

  // Directed row: the stimulus item plus an optional hand-typed result.
  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  cosine_top_k_search #(.ENTRIES(Slots), .DIM(Dim)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the block: stored vectors, query, fill counters.
  shortint   shadow_store [Slots][Dim];
  shortint   shadow_query [Dim];
  int        shadow_count;
  int        shadow_pos;
  out_item_t pending_results[$];
  int        errors;
  int        cycles;
  int        sent;
  bit        in_steady;   // input burst stretch, no gaps
  bit        out_steady;  // output stretch, no stalls

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] cosine_score(int slot, longint unsigned qn);
    longint          dot = 0;
    longint unsigned ss = 0;
    longint unsigned sn;
    longint          q;
    for (int i = 0; i < Dim; i++) begin
      dot += longint'(shadow_query[i]) * longint'(shadow_store[slot][i]);
      ss  += longint'(shadow_store[slot][i]) * longint'(shadow_store[slot][i]);
    end
    sn = int_sqrt(ss);
    if (qn == 0 || sn == 0) return '0;
    q = (dot * 32768) / longint'(qn * sn);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Advances the shadow by one accepted item and returns the results it causes.
  function automatic void predict_item(in_item_t it, ref out_item_t res[$]);
    longint unsigned qq = 0;
    longint unsigned qn;
    logic signed [15:0] sc [Slots];
    bit  taken [Slots];
    int  n, best;
    bit  found;
    out_item_t r;
    res.delete();
    if (shadow_pos == 0) begin
      foreach (shadow_query[i]) shadow_query[i] = 0;
      if (shadow_count < Slots)
        for (int i = 0; i < Dim; i++) shadow_store[shadow_count][i] = 0;
    end
    if (shadow_pos < Dim) begin
      if (!it.kind) begin
        if (shadow_count < Slots) shadow_store[shadow_count][shadow_pos] = it.value;
      end else begin
        shadow_query[shadow_pos] = it.value;
      end
      shadow_pos++;
    end
    if (!it.last) return;
    shadow_pos = 0;
    if (!it.kind) begin
      r = '0;
      r.last_res = 1'b1;
      if (shadow_count < Slots) begin
        r.entry_index = shadow_count[5:0];
        r.status = StStored;
        shadow_count++;
      end else begin
        r.status = StFull;
      end
      res = {res, r};
      return;
    end
    for (int i = 0; i < Dim; i++) qq += longint'(shadow_query[i]) * longint'(shadow_query[i]);
    qn = int_sqrt(qq);
    for (int i = 0; i < shadow_count; i++) begin
      sc[i] = cosine_score(i, qn);
      taken[i] = 1'b0;
    end
    n = (int'(it.top_k) < shadow_count) ? int'(it.top_k) : shadow_count;
    for (int k = 0; k < n; k++) begin
      found = 1'b0;
      best = 0;
      for (int j = 0; j < shadow_count; j++) begin
        if (taken[j]) continue;
        if (!found || sc[j] > sc[best]) begin
          best = j;
          found = 1'b1;
        end
      end
      taken[best] = 1'b1;
      r.entry_index = best[5:0];
      r.score = sc[best];
      r.status = StMatch;
      r.last_res = (k + 1 == n);
      res = {res, r};
    end
  endfunction

  function automatic row_t mk(bit kind, int val, bit last, int k,
                              bit typed = 0, int idx = 0, logic [1:0] st = StMatch);
    row_t r;
    r.it.kind = kind;
    r.it.value = val[15:0];
    r.it.last = last;
    r.it.top_k = k[6:0];
    r.typed = typed;
    r.res.entry_index = idx[5:0];
    r.res.score = '0;
    r.res.status = st;
    r.res.last_res = 1'b1;
    return r;
  endfunction

  // Drives one item, waits for the handshake, then the item's gap.
  task automatic send_item(in_item_t it, bit typed = 0, out_item_t typed_res = '0);
    out_item_t res[$];
    int gap;
    in_item_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(it, res);
    if (typed) begin
      // hand-typed result replaces the computed one
      res.delete();
      res = {res, typed_res};
    end
    foreach (res[i]) pending_results = {pending_results, res[i]};
    sent++;
    if (sent % 40 == 0) in_steady = ($urandom_range(0, 3) == 0);
    gap = in_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 4)) - 2);  // small, gives ties
      default: return 16'($urandom);
    endcase
  endfunction

  // Random vector: one kind (sometimes mixed), length mostly short,
  // now and then a full or an overlong vector.
  task automatic send_vector(bit kind);
    int len;
    int p;
    bit mixed;
    in_item_t it;
    p = $urandom_range(0, 99);
    if (p < 90)      len = $urandom_range(1, 3);
    else if (p < 96) len = $urandom_range(4, 16);
    else if (p < 98) len = Dim;
    else             len = $urandom_range(Dim + 1, Dim + 6);
    mixed = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      it.kind = (mixed && i != len - 1) ? 1'($urandom) : kind;
      it.value = rand_value();
      it.last = (i == len - 1);
      it.top_k = ($urandom_range(0, 5) == 0) ? 7'($urandom) : 7'($urandom_range(0, 64));
      send_item(it);
    end
  endtask

  // Result side: random stall before each item, then wait for it.
  initial begin
    int stall;
    int got = 0;
    @(posedge rst_ni);
    forever begin
      if (got % 50 == 0) out_steady = ($urandom_range(0, 3) == 0);
      stall = out_steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got++;
    end
  end

  // Result checker: compares each accepted item with the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, got %p", $time, out_item_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.entry_index !== want.entry_index) begin
          $display("%0t: entry_index expected %0d actual %0d", $time,
                   want.entry_index, out_item_o.entry_index);
          errors++;
        end
        if (out_item_o.score !== want.score) begin
          $display("%0t: score expected %0d actual %0d", $time, want.score,
                   out_item_o.score);
          errors++;
        end
        if (out_item_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_item_o.status);
          errors++;
        end
        if (out_item_o.last_res !== want.last_res) begin
          $display("%0t: last_res expected %0d actual %0d", $time, want.last_res,
                   out_item_o.last_res);
          errors++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    errors = 0;
    cycles = 0;
    sent = 0;
    shadow_count = 0;
    shadow_pos = 0;
    in_steady = 1'b0;
    out_steady = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    rows = {rows, mk(1, 32767, 1, 64)};                    // search of empty store
    rows = {rows, mk(0, 32767, 0, 0)};
    rows = {rows, mk(0, -32768, 1, 0, 1, 0, StStored)};    // extremes into slot 0
    rows = {rows, mk(0, 0, 1, 0, 1, 1, StStored)};         // zero-norm vector
    rows = {rows, mk(0, -32768, 0, 0)};
    rows = {rows, mk(0, -32768, 1, 0, 1, 2, StStored)};
    rows = {rows, mk(0, 1, 0, 0)};
    rows = {rows, mk(0, -1, 1, 0, 1, 3, StStored)};
    rows = {rows, mk(1, 32767, 0, 0)};
    rows = {rows, mk(1, -32768, 1, 64)};                   // all slots, signed scores
    rows = {rows, mk(1, 0, 1, 127)};                       // zero query: ties by slot
    rows = {rows, mk(1, 5, 1, 0)};                         // top_k zero, no result
    rows = {rows, mk(0, 100, 0, 0)};
    rows = {rows, mk(1, -100, 1, 2)};                      // mixed kinds, query last
    rows = {rows, mk(1, -32768, 1, 1)};
    rows = {rows, mk(1, 12345, 0, 0)};
    rows = {rows, mk(0, -7, 1, 0, 1, 4, StStored)};        // mixed kinds, store last
    rows = {rows, mk(1, 1, 1, 3)};
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].res);

    // Random part: fill the store first, then keep mixing stores and queries
    // so full-store drops and wide searches both get exercised.
    while (sent < NItems || shadow_count < Slots) begin
      if (shadow_count < Slots) send_vector($urandom_range(0, 99) < 20);
      else send_vector($urandom_range(0, 99) < 60);
    end
    in_valid_i <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
